/* hw/rtl/rk4do_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rk4do_pkg
// Shared types and constants for the RK4 damped oscillator step block.
// ----------------------------------------------------------------------------
package rk4do_pkg;

    localparam int VW     = 48;            // value width, Q16.32
    localparam int FB     = 32;            // fraction bits
    localparam int STEP_W = VW - 1;        // step size register width
    localparam int CNT_W  = 32;            // step counter width
    localparam int MW     = VW + 1;        // multiplier operand width
    localparam int BLO_W  = 24;            // low operand slice
    localparam int BHI_W  = MW - BLO_W;    // high operand slice, signed
    localparam int PW     = MW + BHI_W;    // partial product width
    localparam int FW     = PW + BLO_W;    // full product width
    localparam int IDX_W  = 3;             // config index width

    // config register indexes
    localparam logic [IDX_W-1:0] REG_STEP  = 3'd0;
    localparam logic [IDX_W-1:0] REG_DAMP  = 3'd1;
    localparam logic [IDX_W-1:0] REG_STIFF = 3'd2;
    localparam logic [IDX_W-1:0] REG_INVI  = 3'd3;
    localparam logic [IDX_W-1:0] REG_A0    = 3'd4;
    localparam logic [IDX_W-1:0] REG_R0    = 3'd5;

    // reset values
    localparam logic [STEP_W-1:0] RST_STEP  = 47'd429497;
    localparam logic [VW-1:0]     RST_DAMP  = 48'd25769803776;
    localparam logic [VW-1:0]     RST_STIFF = 48'd21474836480;
    localparam logic [VW-1:0]     RST_INVI  = 48'd4294967296;
    localparam logic [VW-1:0]     RST_A0    = 48'd42949672960;
    localparam logic [VW-1:0]     RST_R0    = 48'd0;
    localparam logic [VW-1:0]     RST_ANGLE = 48'd42949672960;

    // floor divide by six: halve, bias to non-negative, reciprocal of three
    localparam logic [VW-1:0] DIV_MULT = 48'h5555_5555_5555;
    localparam logic [MW-1:0] DIV_BIAS = 49'h0_C000_0000_0000;
    localparam logic [VW-1:0] Q_BIAS   = 48'h4000_0000_0000;

    localparam logic [1:0] FIRST_STAGE = 2'd0;
    localparam logic [1:0] LAST_STAGE  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_MUL_WB,
        S_DIV_FIX,
        S_DIV_APPLY,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        MOP_DRIVE,
        MOP_DAMP,
        MOP_STIFF,
        MOP_DA,
        MOP_DR,
        MOP_DIV_A,
        MOP_DIV_R
    } t_mop;

    typedef struct packed {
        logic       accept_step;
        logic       load_init;
        logic       mul_lo;
        logic       mul_hi;
        logic       mul_wb;
        logic       div_fix;
        logic       div_apply;
        logic       load_out;
        t_mop       mop;
        logic [1:0] stage;
    } t_dp_cmd;

endpackage : rk4do_pkg
`default_nettype wire

/* hw/rtl/rk4do_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rk4do_ctrl
// Sequencer: steps the shared multiplier through the nineteen products of one
// RK4 step and the two divide-by-six fixups, and owns the word handshakes.
// ----------------------------------------------------------------------------
module rk4do_ctrl
    import rk4do_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_restart,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_dp_cmd      o_cmd
);

    localparam logic [4:0] OP_DRIVE     = 5'd0;
    localparam logic [4:0] OP_DIV_ANGLE = 5'd17;
    localparam logic [4:0] OP_DIV_RATE  = 5'd18;

    localparam logic [1:0] K_DAMP  = 2'd0;
    localparam logic [1:0] K_STIFF = 2'd1;
    localparam logic [1:0] K_DA    = 2'd2;
    localparam logic [1:0] K_DR    = 2'd3;

    t_state     r_state, n_state;
    logic [4:0] r_op, n_op;
    logic       r_out_valid;
    logic [4:0] w_k;
    t_mop       w_mop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_DRIVE;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign w_k         = r_op - 5'd1;

    always_comb begin
        w_mop = MOP_DRIVE;
        if (r_op == OP_DIV_ANGLE) begin
            w_mop = MOP_DIV_A;
        end else if (r_op == OP_DIV_RATE) begin
            w_mop = MOP_DIV_R;
        end else if (r_op != OP_DRIVE) begin
            case (w_k[1:0])
                K_DAMP:  w_mop = MOP_DAMP;
                K_STIFF: w_mop = MOP_STIFF;
                K_DA:    w_mop = MOP_DA;
                K_DR:    w_mop = MOP_DR;
                default: w_mop = MOP_DAMP;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        o_cmd       = '0;
        o_cmd.mop   = w_mop;
        o_cmd.stage = w_k[3:2];
        o_in_ready  = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_restart) begin
                        o_cmd.load_init = 1'b1;
                        n_state         = S_OUT;
                    end else begin
                        o_cmd.accept_step = 1'b1;
                        n_op              = OP_DRIVE;
                        n_state           = S_MUL_LO;
                    end
                end
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_MUL_WB;
            end
            S_MUL_WB: begin
                o_cmd.mul_wb = 1'b1;
                if (r_op == OP_DIV_ANGLE || r_op == OP_DIV_RATE) begin
                    n_state = S_DIV_FIX;
                end else begin
                    n_op    = r_op + 5'd1;
                    n_state = S_MUL_LO;
                end
            end
            S_DIV_FIX: begin
                o_cmd.div_fix = 1'b1;
                n_state       = S_DIV_APPLY;
            end
            S_DIV_APPLY: begin
                o_cmd.div_apply = 1'b1;
                if (r_op == OP_DIV_ANGLE) begin
                    n_op    = OP_DIV_RATE;
                    n_state = S_MUL_LO;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule : rk4do_ctrl
`default_nettype wire

/* hw/rtl/rk4do_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rk4do_dpath
// Datapath: config registers, oscillator state, one shared 49x25 multiplier
// used twice per product, stage accumulators and the divide-by-six fixup.
// ----------------------------------------------------------------------------
module rk4do_dpath
    import rk4do_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_dp_cmd          i_cmd,
    input  wire logic [VW-1:0]    i_drive_torque,
    input  wire logic             i_cfg_valid,
    input  wire logic [IDX_W-1:0] i_cfg_index,
    input  wire logic [VW-1:0]    i_cfg_data,
    output logic [VW-1:0]         o_angle,
    output logic [VW-1:0]         o_rate,
    output logic [CNT_W-1:0]      o_step_number
);

    logic [STEP_W-1:0] r_step;
    logic [VW-1:0]     r_damp, r_stiff, r_invi, r_a0, r_r0;
    logic [VW-1:0]     r_angle, r_rate;
    logic [CNT_W-1:0]  r_count;
    logic [VW-1:0]     r_torque, r_drive, r_acc, r_pa, r_pr, r_sa, r_sr, r_q;
    logic [PW-1:0]     r_plo, r_phi;
    logic [VW-1:0]     r_out_angle, r_out_rate;
    logic [CNT_W-1:0]  r_out_count;

    logic signed [VW-1:0]    w_src, w_half;
    logic [MW-1:0]           w_u;
    logic [MW-1:0]           w_a_u, w_b;
    logic signed [MW-1:0]    w_a;
    logic signed [BHI_W-1:0] w_b_part;
    logic signed [PW-1:0]    w_prod;
    logic [FW-1:0]           w_full;
    logic signed [VW-1:0]    w_f, w_fhalf;
    logic [VW-1:0]           w_f2, w_q;
    logic [MW-1:0]           w_three_q, w_rem;
    logic [VW-1:0]           w_qc;
    logic [VW-1:0]           w_inc;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= RST_STEP;
            r_damp  <= RST_DAMP;
            r_stiff <= RST_STIFF;
            r_invi  <= RST_INVI;
            r_a0    <= RST_A0;
            r_r0    <= RST_R0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_STEP:  r_step  <= i_cfg_data[STEP_W-1:0];
                REG_DAMP:  r_damp  <= i_cfg_data;
                REG_STIFF: r_stiff <= i_cfg_data;
                REG_INVI:  r_invi  <= i_cfg_data;
                REG_A0:    r_a0    <= i_cfg_data;
                REG_R0:    r_r0    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // divide-by-six operand: floor halve, then bias to non-negative
    assign w_src  = (i_cmd.mop == MOP_DIV_R) ? r_sr : r_sa;
    assign w_half = w_src >>> 1;
    assign w_u    = {w_half[VW-1], w_half} + DIV_BIAS;

    always_comb begin
        case (i_cmd.mop)
            MOP_DRIVE: begin
                w_a_u = {r_torque[VW-1], r_torque};
                w_b   = {r_invi[VW-1], r_invi};
            end
            MOP_DAMP: begin
                w_a_u = {r_pr[VW-1], r_pr};
                w_b   = {r_damp[VW-1], r_damp};
            end
            MOP_STIFF: begin
                w_a_u = {r_pa[VW-1], r_pa};
                w_b   = {r_stiff[VW-1], r_stiff};
            end
            MOP_DA: begin
                w_a_u = {r_pr[VW-1], r_pr};
                w_b   = {2'b00, r_step};
            end
            MOP_DR: begin
                w_a_u = {r_acc[VW-1], r_acc};
                w_b   = {2'b00, r_step};
            end
            MOP_DIV_A, MOP_DIV_R: begin
                w_a_u = w_u;
                w_b   = {1'b0, DIV_MULT};
            end
            default: begin
                w_a_u = '0;
                w_b   = '0;
            end
        endcase
    end

    assign w_a      = $signed(w_a_u);
    assign w_b_part = i_cmd.mul_hi ? $signed(w_b[MW-1:BLO_W])
                                   : $signed({1'b0, w_b[BLO_W-1:0]});
    assign w_prod   = w_a * w_b_part;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_lo) begin
            r_plo <= w_prod;
        end
        if (i_cmd.mul_hi) begin
            r_phi <= w_prod;
        end
    end

    assign w_full  = {r_phi, {BLO_W{1'b0}}} + {{BLO_W{r_plo[PW-1]}}, r_plo};
    assign w_f     = w_full[FB+VW-1:FB];
    assign w_fhalf = w_f >>> 1;
    assign w_f2    = {w_f[VW-2:0], 1'b0};
    assign w_q     = w_full[2*VW-1:VW];

    // quotient estimate is exact or one low
    assign w_three_q = {r_q, 1'b0} + {1'b0, r_q};
    assign w_rem     = w_u - w_three_q;
    assign w_qc      = r_q + {{(VW-1){1'b0}}, (w_rem >= 49'd3)};

    assign w_inc = (i_cmd.stage == FIRST_STAGE || i_cmd.stage == 2'd1) ? w_fhalf : w_f;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_step) begin
            r_torque <= i_drive_torque;
            r_pa     <= r_angle;
            r_pr     <= r_rate;
        end
        if (i_cmd.mul_wb) begin
            case (i_cmd.mop)
                MOP_DRIVE: r_drive <= w_f;
                MOP_DAMP:  r_acc   <= r_drive - w_f;
                MOP_STIFF: r_acc   <= r_acc - w_f;
                MOP_DA: begin
                    if (i_cmd.stage == FIRST_STAGE) begin
                        r_sa <= w_f;
                    end else if (i_cmd.stage == LAST_STAGE) begin
                        r_sa <= r_sa + w_f;
                    end else begin
                        r_sa <= r_sa + w_f2;
                    end
                    r_pa <= r_angle + w_inc;
                end
                MOP_DR: begin
                    if (i_cmd.stage == FIRST_STAGE) begin
                        r_sr <= w_f;
                    end else if (i_cmd.stage == LAST_STAGE) begin
                        r_sr <= r_sr + w_f;
                    end else begin
                        r_sr <= r_sr + w_f2;
                    end
                    r_pr <= r_rate + w_inc;
                end
                MOP_DIV_A, MOP_DIV_R: r_q <= w_q;
                default: ;
            endcase
        end
        if (i_cmd.div_fix) begin
            r_q <= w_qc - Q_BIAS;
        end
    end

    // oscillator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= RST_ANGLE;
            r_rate  <= '0;
            r_count <= '0;
        end else if (i_cmd.load_init) begin
            r_angle <= r_a0;
            r_rate  <= r_r0;
            r_count <= '0;
        end else if (i_cmd.div_apply) begin
            if (i_cmd.mop == MOP_DIV_A) begin
                r_angle <= r_angle + r_q;
            end else begin
                r_rate  <= r_rate + r_q;
                r_count <= r_count + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_angle <= r_angle;
            r_out_rate  <= r_rate;
            r_out_count <= r_count;
        end
    end

    assign o_angle       = r_out_angle;
    assign o_rate        = r_out_rate;
    assign o_step_number = r_out_count;

endmodule : rk4do_dpath
`default_nettype wire

/* hw/rtl/rk4_damped_oscillator_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rk4_damped_oscillator_step
// One fourth-order Runge-Kutta step of a damped, driven rotor per step word.
// ----------------------------------------------------------------------------
// A step word runs the single 49x25 multiplier through 19 products (drive
// scaling, four per stage, two reciprocal divides by six), each as a low
// pass, a high pass and a writeback, and each divide adds a fixup and an
// apply step. A restart word loads the initial angle and rate, count zero.
// A new word is taken only once the last result is loaded for output.
// The result register lets a new word be accepted while the last result
// waits. Config writes are always ready and are meant only while idle.
// ----------------------------------------------------------------------------
module rk4_damped_oscillator_step
    import rk4do_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [VW-1:0]    i_drive_torque,
    input  wire logic             i_restart,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [VW-1:0]         o_angle,
    output logic [VW-1:0]         o_rate,
    output logic [CNT_W-1:0]      o_step_number,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [IDX_W-1:0] i_cfg_index,
    input  wire logic [VW-1:0]    i_cfg_data
);

    t_dp_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    rk4do_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_restart   (i_restart),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    rk4do_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_drive_torque (i_drive_torque),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_angle        (o_angle),
        .o_rate         (o_rate),
        .o_step_number  (o_step_number)
    );

endmodule : rk4_damped_oscillator_step
`default_nettype wire
